// ----- sv/imu_bias_calibrate_correct_macros.svh -----
// Assertion macros shared by the IMU bias calibration RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef IMU_BIAS_CALIBRATE_CORRECT_MACROS_SVH
`define IMU_BIAS_CALIBRATE_CORRECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMUBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("imubc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IMUBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("imubc assertion failed");

`endif

// ----- sv/imubc_pkg.sv -----
// Shared types and constants for the IMU bias calibration block.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package imubc_pkg;

  // Calibration run length. Must be a power of two (shift-based averaging).
  localparam int unsigned NumCalSamples = 64;
  localparam int unsigned CalShift      = $clog2(NumCalSamples);

  // Field widths.
  localparam int unsigned DataW  = 16;
  localparam int unsigned OneGW  = 15;
  localparam int unsigned AxisW  = 2;
  localparam int unsigned NumAxes = 6;
  localparam int unsigned NumAccel = 3;

  // Running sum holds NumCalSamples 16-bit values without overflow.
  localparam int unsigned SumW = DataW + CalShift;
  localparam logic [SumW-1:0] RemMask = SumW'(NumCalSamples - 1);

  // Sample counter of the current run.
  localparam int unsigned CntW = (NumCalSamples > 1) ? $clog2(NumCalSamples) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(NumCalSamples - 1);

  // Reset value of the one-g count register.
  localparam logic [OneGW-1:0] OneGReset = 15'd16384;

  // Operation codes of an input transaction; code 3 behaves as a measurement.
  typedef enum logic [1:0] {
    OpMeasure   = 2'd0,
    OpCalSample = 2'd1,
    OpRestart   = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    CfgDownAxis = 1'b0,
    CfgOneG     = 1'b1
  } cfg_idx_e;

  // Per-transaction control broadcast to every lane.
  typedef struct packed {
    logic load;    // transaction accepted this cycle
    logic cal;     // calibration sample
    logic finish;  // this sample completes the run
    logic clear;   // restart: drop the running sums
    logic apply;   // offsets are in force
  } lane_ctrl_t;

  // One result transaction as held in the output register.
  typedef struct packed {
    logic [NumAxes-1:0][DataW-1:0] fixed;
    logic                          is_calibrated;
    logic                          calibration_finished;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/imubc_if.sv -----
// Valid/ready stream interfaces for the input and result transactions.
// Depends on imubc_pkg for field widths.
`default_nettype none

interface imubc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             operation;
  logic signed [imubc_pkg::DataW-1:0]     accel_x_raw;
  logic signed [imubc_pkg::DataW-1:0]     accel_y_raw;
  logic signed [imubc_pkg::DataW-1:0]     accel_z_raw;
  logic signed [imubc_pkg::DataW-1:0]     gyro_x_raw;
  logic signed [imubc_pkg::DataW-1:0]     gyro_y_raw;
  logic signed [imubc_pkg::DataW-1:0]     gyro_z_raw;

  modport source (
    output valid, operation, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );
  modport sink (
    input  valid, operation, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

interface imubc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [imubc_pkg::DataW-1:0]     accel_x_fixed;
  logic signed [imubc_pkg::DataW-1:0]     accel_y_fixed;
  logic signed [imubc_pkg::DataW-1:0]     accel_z_fixed;
  logic signed [imubc_pkg::DataW-1:0]     gyro_x_fixed;
  logic signed [imubc_pkg::DataW-1:0]     gyro_y_fixed;
  logic signed [imubc_pkg::DataW-1:0]     gyro_z_fixed;
  logic                                   is_calibrated;
  logic                                   calibration_finished;

  modport source (
    output valid, accel_x_fixed, accel_y_fixed, accel_z_fixed,
           gyro_x_fixed, gyro_y_fixed, gyro_z_fixed,
           is_calibrated, calibration_finished,
    input  ready
  );
  modport sink (
    input  valid, accel_x_fixed, accel_y_fixed, accel_z_fixed,
           gyro_x_fixed, gyro_y_fixed, gyro_z_fixed,
           is_calibrated, calibration_finished,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/imubc_lane.sv -----
// One axis lane: running sum, bias offset and the corrected sample.
// Depends on imubc_pkg for widths and the lane control struct.
`default_nettype none

module imubc_lane (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire imubc_pkg::lane_ctrl_t            ctrl_i,
  input  wire logic [imubc_pkg::DataW-1:0]      raw_i,
  input  wire logic [imubc_pkg::DataW-1:0]      one_g_sub_i,
  output logic [imubc_pkg::DataW-1:0]           fixed_o
);

  logic signed [imubc_pkg::SumW-1:0] sum_q, sum_d;
  logic signed [imubc_pkg::SumW-1:0] sum_new;
  logic signed [imubc_pkg::SumW-1:0] quot;
  logic                              round_up;
  logic [imubc_pkg::DataW-1:0]       off_q, off_d;

  // Sum including the current sample, sign-extended to the sum width.
  assign sum_new = sum_q + $signed({{(imubc_pkg::SumW - imubc_pkg::DataW){raw_i[15]}}, raw_i});

  // Average truncated toward zero: arithmetic shift, then bump negative
  // values that had a nonzero remainder.
  assign quot     = sum_new >>> imubc_pkg::CalShift;
  assign round_up = sum_new[imubc_pkg::SumW-1] && ((sum_new & imubc_pkg::RemMask) != '0);

  // Next sum and offset.
  always_comb begin
    sum_d = sum_q;
    off_d = off_q;
    if (ctrl_i.load) begin
      if (ctrl_i.finish) begin
        sum_d = '0;
        off_d = quot[imubc_pkg::DataW-1:0] + {15'd0, round_up} - one_g_sub_i;
      end else if (ctrl_i.cal) begin
        sum_d = sum_new;
      end else if (ctrl_i.clear) begin
        sum_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      off_q <= '0;
    end else begin
      sum_q <= sum_d;
      off_q <= off_d;
    end
  end

  // Correction uses the offset in force before this transaction.
  assign fixed_o = ctrl_i.apply ? (raw_i - off_q) : raw_i;

endmodule

`default_nettype wire

// ----- sv/imubc_merge.sv -----
// Merge stage: gathers the six lane results and flags into the output register.
// Depends on imubc_pkg (result_t) and imubc_if (result channel).
`default_nettype none

module imubc_merge (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire imubc_pkg::result_t     result_i,
  output logic                        free_o,
  imubc_out_if.source                 out_ch
);

  logic                valid_q, valid_d;
  imubc_pkg::result_t  res_q;

  // The register can take a new result when empty or being drained.
  assign free_o = !valid_q || out_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ch.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_ch.valid                = valid_q;
  assign out_ch.accel_x_fixed        = res_q.fixed[0];
  assign out_ch.accel_y_fixed        = res_q.fixed[1];
  assign out_ch.accel_z_fixed        = res_q.fixed[2];
  assign out_ch.gyro_x_fixed         = res_q.fixed[3];
  assign out_ch.gyro_y_fixed         = res_q.fixed[4];
  assign out_ch.gyro_z_fixed         = res_q.fixed[5];
  assign out_ch.is_calibrated        = res_q.is_calibrated;
  assign out_ch.calibration_finished = res_q.calibration_finished;

endmodule

`default_nettype wire

// ----- sv/imu_bias_calibrate_correct.sv -----
// Top level of the IMU static bias calibration and correction block.
// Depends on imubc_pkg, imubc_if, imubc_lane, imubc_merge and the macros header.
//
// Usage:
//   in_ch carries one raw six-axis sample per transaction with an operation
//   code: measure, calibration sample, or restart of the running sums.
//   out_ch returns exactly one result per input transaction: the six counts
//   minus the offsets in force before that transaction (raw counts before the
//   first calibration), plus is_calibrated and calibration_finished flags.
//   After NumCalSamples calibration samples the offsets are recomputed; the
//   next transaction already sees them.
//   A transaction's result is registered and shows on out_ch in the cycle after
//   it is accepted. Throughput is one transaction per cycle while out_ch.ready
//   is high, set by the six lanes each closing their sum/offset update on accept.
//   A result waiting in the output register does not block a new input as long
//   as out_ch.ready is high in the same cycle; when the receiver stalls, in_ch
//   stalls with it and the held result stays on the port.
//   Reset clears sums, counter and offsets, drops the calibrated flag, empties
//   the output register and restores down_axis 0 and one_g_counts 16384.
//   The user writes configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no transaction is in flight; the block does not enforce this.
`default_nettype none

`include "imu_bias_calibrate_correct_macros.svh"

module imu_bias_calibrate_correct (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  imubc_in_if.sink                           in_ch,
  imubc_out_if.source                        out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [imubc_pkg::OneGW-1:0]   cfg_wdata_i
);

  logic                              accept;
  logic                              free;
  logic                              is_cal;
  logic                              is_restart;
  logic                              finish;
  logic [imubc_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                              calibrated_q, calibrated_d;
  logic [imubc_pkg::AxisW-1:0]       down_axis_q;
  logic [imubc_pkg::OneGW-1:0]       one_g_q;
  imubc_pkg::lane_ctrl_t             ctrl;
  imubc_pkg::result_t                result;
  logic [imubc_pkg::NumAxes-1:0][imubc_pkg::DataW-1:0] raw;
  logic [imubc_pkg::NumAxes-1:0][imubc_pkg::DataW-1:0] one_g_sub;
  logic [imubc_pkg::NumAxes-1:0][imubc_pkg::DataW-1:0] fixed;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_axis_q <= '0;
      one_g_q     <= imubc_pkg::OneGReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imubc_pkg::CfgDownAxis: down_axis_q <= cfg_wdata_i[imubc_pkg::AxisW-1:0];
        imubc_pkg::CfgOneG:     one_g_q     <= cfg_wdata_i;
        default:                one_g_q     <= one_g_q;
      endcase
    end
  end

  // Input handshake and operation decode.
  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;
  assign is_cal      = (in_ch.operation == imubc_pkg::OpCalSample);
  assign is_restart  = (in_ch.operation == imubc_pkg::OpRestart);
  assign finish      = is_cal && (cnt_q == imubc_pkg::CntMax);

  // Run counter and calibrated flag.
  always_comb begin
    cnt_d        = cnt_q;
    calibrated_d = calibrated_q;
    if (accept) begin
      if (finish || is_restart) begin
        cnt_d = '0;
      end else if (is_cal) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (finish) begin
        calibrated_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      calibrated_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      calibrated_q <= calibrated_d;
    end
  end

  // Control broadcast to the lanes.
  assign ctrl.load   = accept;
  assign ctrl.cal    = is_cal;
  assign ctrl.finish = finish;
  assign ctrl.clear  = is_restart;
  assign ctrl.apply  = calibrated_q;

  assign raw[0] = in_ch.accel_x_raw;
  assign raw[1] = in_ch.accel_y_raw;
  assign raw[2] = in_ch.accel_z_raw;
  assign raw[3] = in_ch.gyro_x_raw;
  assign raw[4] = in_ch.gyro_y_raw;
  assign raw[5] = in_ch.gyro_z_raw;

  // One lane per axis; only the down-facing accelerometer axis removes one g.
  for (genvar g = 0; g < imubc_pkg::NumAxes; g++) begin : g_lane
    if (g < imubc_pkg::NumAccel) begin : g_accel
      assign one_g_sub[g] = (down_axis_q == imubc_pkg::AxisW'(g)) ? {1'b0, one_g_q} : '0;
    end else begin : g_gyro
      assign one_g_sub[g] = '0;
    end

    imubc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .raw_i       (raw[g]),
      .one_g_sub_i (one_g_sub[g]),
      .fixed_o     (fixed[g])
    );
  end

  // Merge lane results into the output register.
  assign result.fixed                = fixed;
  assign result.is_calibrated        = calibrated_q;
  assign result.calibration_finished = finish;

  imubc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (free),
    .out_ch   (out_ch)
  );

  // The run counter never reaches the run length.
  `IMUBC_ASSERT_SAME(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= imubc_pkg::CntMax)
  // A finishing sample leaves the block calibrated with a flagged result.
  `IMUBC_ASSERT_NEXT(a_finish_sets, clk_i, rst_ni, accept && finish,
                     calibrated_q && out_ch.valid && out_ch.calibration_finished)
  // A restart empties the run counter.
  `IMUBC_ASSERT_NEXT(a_restart_clr, clk_i, rst_ni, accept && is_restart, cnt_q == '0)
  // Every accepted transaction yields a pending result next cycle.
  `IMUBC_ASSERT_NEXT(a_result, clk_i, rst_ni, accept, out_ch.valid)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the IMU bias calibration and correction block.
// Depends on imubc_pkg, the imubc_in_if / imubc_out_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import imubc_pkg::*;

  // Operation code 3 has no package name; the block treats it as a measurement.
  localparam logic [1:0] OpSpare = 2'd3;

  // Content styles of generated samples.
  localparam int StyleRandom  = 0;
  localparam int StyleBias    = 1;
  localparam int StyleExtreme = 2;
  localparam int StyleFloor   = 3;

  localparam int unsigned PhaseItems = 215;
  localparam int unsigned NumPhases  = 7;

  typedef logic [NumAxes-1:0][DataW-1:0] axes_t;

  // One input transaction; axes 0..2 are accel x/y/z, 3..5 gyro x/y/z.
  typedef struct packed {
    logic [1:0] op;
    axes_t      axes;
  } imu_sample_t;

  // One result transaction in the same axis order.
  typedef struct packed {
    axes_t axes;
    logic  is_cal;
    logic  finished;
  } corrected_t;

  // Tracks the calibration state, predicts corrected samples and checks results.
  class bias_scoreboard;
    logic [AxisW-1:0] down_axis;
    logic [OneGW-1:0] one_g;
    int               axis_sums[NumAxes];
    int unsigned      cal_count;
    logic [DataW-1:0] offsets[NumAxes];
    bit               calibrated;
    corrected_t       expected_corrected[$];
    int unsigned      errors;
    string            axis_name[NumAxes];

    function new();
      axis_name = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};
      down_axis = '0;
      one_g = OneGReset;
      clear_run();
      foreach (offsets[i]) offsets[i] = '0;
      calibrated = 1'b0;
      errors = 0;
    endfunction

    function void clear_run();
      foreach (axis_sums[i]) axis_sums[i] = 0;
      cal_count = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [OneGW-1:0] value);
      if (idx == CfgDownAxis) begin
        down_axis = value[AxisW-1:0];
      end else begin
        one_g = value;
      end
    endfunction

    // Predicts the result of an accepted sample, then advances the calibration state.
    function void note_sample(imu_sample_t s);
      corrected_t              e;
      logic signed [DataW-1:0] raw;
      int                      mean;
      int                      i;
      e.is_cal = calibrated;
      e.finished = 1'b0;
      for (i = 0; i < NumAxes; i++) begin
        e.axes[i] = s.axes[i] - (calibrated ? offsets[i] : '0);
      end
      if (s.op == OpCalSample) begin
        for (i = 0; i < NumAxes; i++) begin
          raw = s.axes[i];
          axis_sums[i] += raw;
        end
        cal_count++;
        if (cal_count == NumCalSamples) begin
          // Average truncates toward zero; the down axis also loses one g.
          for (i = 0; i < NumAxes; i++) begin
            mean = axis_sums[i] / int'(NumCalSamples);
            if (i < NumAccel && i == down_axis) begin
              mean -= int'(one_g);
            end
            offsets[i] = mean[DataW-1:0];
          end
          calibrated = 1'b1;
          e.finished = 1'b1;
          clear_run();
        end
      end else if (s.op == OpRestart) begin
        clear_run();
      end
      expected_corrected.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    // Compares a result with the oldest prediction, field by field.
    task check_result(corrected_t got);
      corrected_t e;
      int         i;
      if (expected_corrected.size() == 0) begin
        report("result transaction arrived with nothing expected");
        return;
      end
      e = expected_corrected.pop_front();
      for (i = 0; i < NumAxes; i++) begin
        if (got.axes[i] !== e.axes[i]) begin
          report($sformatf("%s_fixed got %h want %h", axis_name[i], got.axes[i], e.axes[i]));
        end
      end
      if (got.is_cal !== e.is_cal) begin
        report($sformatf("is_calibrated got %b want %b", got.is_cal, e.is_cal));
      end
      if (got.finished !== e.finished) begin
        report($sformatf("calibration_finished got %b want %b", got.finished, e.finished));
      end
    endtask

    function int unsigned pending();
      return expected_corrected.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  cfg_idx_e         cfg_idx_i;
  logic [OneGW-1:0] cfg_wdata_i;

  imubc_in_if  in_ch ();
  imubc_out_if out_ch ();

  bias_scoreboard sb;
  int unsigned    burst_left = 0;
  int unsigned    items_sent = 0;
  bit             steady = 1'b0;

  imu_bias_calibrate_correct dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver stalls: modes of random length, from always ready to a fixed pattern.
  initial begin
    int unsigned mode_left;
    int unsigned mode;
    int unsigned tick;
    mode_left = 0;
    mode = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (tick % 5 > 1);
        default: out_ch.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Monitor: check results first, then predict from the accepted input transaction.
  always @(posedge clk_i) begin
    corrected_t  got;
    imu_sample_t acc;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.axes[0] = out_ch.accel_x_fixed;
        got.axes[1] = out_ch.accel_y_fixed;
        got.axes[2] = out_ch.accel_z_fixed;
        got.axes[3] = out_ch.gyro_x_fixed;
        got.axes[4] = out_ch.gyro_y_fixed;
        got.axes[5] = out_ch.gyro_z_fixed;
        got.is_cal = out_ch.is_calibrated;
        got.finished = out_ch.calibration_finished;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        acc.op = in_ch.operation;
        acc.axes[0] = in_ch.accel_x_raw;
        acc.axes[1] = in_ch.accel_y_raw;
        acc.axes[2] = in_ch.accel_z_raw;
        acc.axes[3] = in_ch.gyro_x_raw;
        acc.axes[4] = in_ch.gyro_y_raw;
        acc.axes[5] = in_ch.gyro_z_raw;
        sb.note_sample(acc);
      end
    end
  end

  // Builds a sample in the given content style around a per-run bias.
  function automatic imu_sample_t make_sample(logic [1:0] op, int style, axes_t bias);
    imu_sample_t s;
    int          i;
    s.op = op;
    for (i = 0; i < NumAxes; i++) begin
      case (style)
        StyleBias: s.axes[i] = bias[i] + DataW'($urandom_range(0, 127)) - DataW'(64);
        StyleExtreme: begin
          case ($urandom_range(0, 3))
            0: s.axes[i] = 16'h7FFF;
            1: s.axes[i] = 16'h8000;
            2: s.axes[i] = 16'hFFFF;
            default: s.axes[i] = 16'h0000;
          endcase
        end
        StyleFloor: s.axes[i] = 16'h8000;
        default: s.axes[i] = DataW'($urandom);
      endcase
    end
    return s;
  endfunction

  function automatic axes_t random_axes();
    axes_t a;
    int    i;
    for (i = 0; i < NumAxes; i++) a[i] = DataW'($urandom);
    return a;
  endfunction

  // Sends one transaction; the sender works in bursts with random gaps between them.
  task automatic send_sample(imu_sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= s.op;
    in_ch.accel_x_raw <= s.axes[0];
    in_ch.accel_y_raw <= s.axes[1];
    in_ch.accel_z_raw <= s.axes[2];
    in_ch.gyro_x_raw <= s.axes[3];
    in_ch.gyro_y_raw <= s.axes[4];
    in_ch.gyro_z_raw <= s.axes[5];
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stops sending and waits until every result is back, plus the block's latency.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes both configuration registers on consecutive edges.
  task automatic cfg_write(logic [AxisW-1:0] down, logic [OneGW-1:0] one_g);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgDownAxis;
    cfg_wdata_i <= OneGW'(down);
    @(posedge clk_i);
    sb.write_reg(CfgDownAxis, OneGW'(down));
    cfg_idx_i <= CfgOneG;
    cfg_wdata_i <= one_g;
    @(posedge clk_i);
    sb.write_reg(CfgOneG, one_g);
    cfg_we_i <= 1'b0;
  endtask

  // A calibration run with measurements mixed in; a broken run stops early,
  // sometimes followed by a restart.
  task automatic cal_run(int style, bit broken);
    axes_t       bias;
    int unsigned cut;
    int unsigned k;
    bias = random_axes();
    cut = broken ? $urandom_range(1, NumCalSamples - 1) : NumCalSamples;
    for (k = 0; k < cut; k++) begin
      if ($urandom_range(0, 7) == 0) send_sample(make_sample(OpMeasure, StyleRandom, bias));
      send_sample(make_sample(OpCalSample, style, bias));
    end
    if (broken && $urandom_range(0, 1) == 1) begin
      send_sample(make_sample(OpRestart, StyleRandom, bias));
    end
  endtask

  // One phase under a fixed configuration: mostly calibration runs, some noise.
  task automatic run_phase();
    int unsigned start;
    int unsigned n;
    int unsigned k;
    logic [1:0]  op;
    start = items_sent;
    // Every phase opens with a full run at the most negative counts.
    cal_run(StyleFloor, 1'b0);
    while (items_sent - start < PhaseItems) begin
      if ($urandom_range(0, 9) < 7) begin
        cal_run($urandom_range(StyleRandom, StyleExtreme), $urandom_range(0, 4) == 0);
      end else begin
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          op = $urandom_range(0, 3);
          send_sample(make_sample(op, StyleRandom, random_axes()));
        end
      end
    end
  endtask

  initial begin
    imu_sample_t s;
    axes_t       zero_bias;
    int unsigned p;
    sb = new();
    zero_bias = '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OpMeasure;
    in_ch.accel_x_raw <= '0;
    in_ch.accel_y_raw <= '0;
    in_ch.accel_z_raw <= '0;
    in_ch.gyro_x_raw <= '0;
    in_ch.gyro_y_raw <= '0;
    in_ch.gyro_z_raw <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgDownAxis;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: uncalibrated pass-through at the extremes, every operation code,
    // and a restart that drops a partial run.
    s.op = OpMeasure;
    s.axes = '0;
    send_sample(s);
    s.axes = {NumAxes{16'h7FFF}};
    send_sample(s);
    s.axes = {NumAxes{16'h8000}};
    send_sample(s);
    s.axes = {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF};
    send_sample(s);
    s.op = OpSpare;
    s.axes = {16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000};
    send_sample(s);
    s.op = OpRestart;
    s.axes = {NumAxes{16'hFFFF}};
    send_sample(s);
    s.op = OpCalSample;
    s.axes = {NumAxes{16'h7FFF}};
    send_sample(s);
    s.axes = {NumAxes{16'h8000}};
    send_sample(s);
    send_sample(make_sample(OpRestart, StyleExtreme, zero_bias));
    send_sample(make_sample(OpMeasure, StyleExtreme, zero_bias));

    // Random phases, each under its own configuration; the first keeps reset values.
    for (p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1: cfg_write(2'd1, 15'd32767);
          2: cfg_write(2'd2, 15'd1);
          3: cfg_write(2'd3, 15'd16384);
          4: cfg_write(2'd0, 15'd0);
          5: cfg_write(2'd2, OneGW'($urandom_range(1, 32767)));
          default: cfg_write(AxisW'($urandom_range(0, 2)), 15'd32767);
        endcase
      end
      steady = (p % 3 == 2);
      run_phase();
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
